FILE: hw/rtl/beat_interval_heart_rate_macros.svh
// Assertion helpers for the beat interval heart rate block.
// The macros expect signals named clk and rst_n in the enclosing scope.
`ifndef BEAT_INTERVAL_HEART_RATE_MACROS_SVH
`define BEAT_INTERVAL_HEART_RATE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BIHR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// Next-cycle implication, checked outside reset.
`define BIHR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

FILE: hw/rtl/bihr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bihr_pkg;

  localparam int TIME_W         = 32;
  localparam int CODE_W         = 8;
  localparam int SR_W           = 16;
  localparam int RATE_W         = 24;
  localparam int KIND_W         = 2;
  localparam int RATE_FRAC_BITS = 8;

  // 180 * sample rate is kept as one product; the six-interval rate uses twice it.
  localparam int SR_FACTOR  = 180;
  localparam int SR_RESET   = 250;
  localparam int PROD_W     = 24;
  localparam int PROD_RESET = SR_FACTOR * SR_RESET;

  // Sum of six 32-bit intervals needs 35 bits.
  localparam int DIVISOR_W  = 35;
  localparam int NUM_W      = PROD_W + RATE_FRAC_BITS + 1;
  localparam int DIVIDEND_W = ((NUM_W > DIVISOR_W) ? NUM_W : DIVISOR_W) + 1;
  localparam int CNT_W      = $clog2(DIVIDEND_W);

  localparam logic [KIND_W-1:0] KIND_COPY  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RATE3 = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RATE6 = 2'd2;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [RATE_W-1:0] rate;
  } div_rsp_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bihr_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle, saturating to the rate width.
module bihr_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bihr_pkg::div_req_t req,
  output bihr_pkg::div_rsp_t     rsp
);

  logic                            busy_r, busy_nxt;
  logic                            done_r, done_nxt;
  logic [bihr_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [bihr_pkg::DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [bihr_pkg::DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [bihr_pkg::DIVISOR_W-1:0]  dvs_r, dvs_nxt;
  logic [bihr_pkg::DIVISOR_W:0]    trial;
  logic [bihr_pkg::DIVISOR_W+1:0]  diff;
  logic                            sub_ok;

  always_comb begin
    trial  = {rem_r, quo_r[bihr_pkg::DIVIDEND_W-1]};
    diff   = {1'b0, trial} - {2'b00, dvs_r};
    sub_ok = ~diff[bihr_pkg::DIVISOR_W+1];

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;

    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = sub_ok ? diff[bihr_pkg::DIVISOR_W-1:0] : trial[bihr_pkg::DIVISOR_W-1:0];
      quo_nxt = {quo_r[bihr_pkg::DIVIDEND_W-2:0], sub_ok};
      cnt_nxt = cnt_r + bihr_pkg::CNT_W'(1);
      if (cnt_r == bihr_pkg::CNT_W'(bihr_pkg::DIVIDEND_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.rate = (|quo_r[bihr_pkg::DIVIDEND_W-1:bihr_pkg::RATE_W]) ?
                    '1 : quo_r[bihr_pkg::RATE_W-1:0];

endmodule

`default_nettype wire

FILE: hw/rtl/beat_interval_heart_rate.sv
`timescale 1ns / 1ps
`default_nettype none
// Beat interval heart rate. Annotation words enter on the in_ stream and result words
// leave on the out_ stream. Each input word yields up to three result words: a copy of
// the annotation (unless it is a measurement), a rate over the last three beat intervals,
// and a rate over the last six normal-to-normal intervals. The final word of an input is
// marked with out_tlast. The sample rate is to be written through cfg_wr_en / cfg_wr_data
// only while the block is idle; the block itself does not enforce this. It resets to 250
// samples per second. The block takes one word at a time: in_tready is low from acceptance
// until the sequencer has finished the word. Each rate takes one pass of the shared
// restoring divider, which produces one quotient bit per cycle.
// Reset clears the beat history, the interval window and the output valid flag, and
// restores the sample rate. When the receiver stalls, the pending result word holds in
// the output register and the sequencer waits; the next input word can be accepted while
// the last result of the previous one still waits in the output register.
module beat_interval_heart_rate (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,   // sample_rate_hz
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,      // sample_time[31:0], ann_code[39:32]
  input  wire logic [2:0]  in_tuser,      // is_beat[0], is_normal_beat[1], is_measurement[2]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,     // out_time[31:0], out_code[39:32], rate_bpm[63:40]
  output logic [1:0]       out_tuser,     // result_kind[1:0]
  output logic             out_tlast      // last_result
);

`include "beat_interval_heart_rate_macros.svh"

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_SUM    = 10'b0000000010,
    S_SHIFT  = 10'b0000000100,
    S_COPY   = 10'b0000001000,
    S_DIV1   = 10'b0000010000,
    S_DIV1W  = 10'b0000100000,
    S_EMIT1  = 10'b0001000000,
    S_DIV2   = 10'b0010000000,
    S_DIV2W  = 10'b0100000000,
    S_EMIT2  = 10'b1000000000
  } state_t;

  localparam int TW = bihr_pkg::TIME_W;
  localparam int DW = bihr_pkg::DIVISOR_W;
  localparam int NW = bihr_pkg::DIVIDEND_W;

  state_t state_r, state_nxt;

  // 180 times the sample rate, updated on each configuration write.
  logic [bihr_pkg::PROD_W-1:0] prod_r, prod_nxt;

  // Beat history and normal interval window with its running sum.
  logic [TW-1:0] bt_r  [3];
  logic [TW-1:0] bt_nxt[3];
  logic [TW-1:0] nn_r  [5];
  logic [TW-1:0] nn_nxt[5];
  logic [DW-1:0] sum_r, sum_nxt;
  logic          prevn_r, prevn_nxt;

  // Per-item work registers.
  logic [TW-1:0]              t_r, t_nxt;
  logic [bihr_pkg::CODE_W-1:0] code_r, code_nxt;
  logic [TW-1:0]              span_r, span_nxt;
  logic [TW-1:0]              nn0_r, nn0_nxt;
  logic [DW-1:0]              div2_r, div2_nxt;
  logic                       copy_r, copy_nxt;
  logic                       r1_r, r1_nxt;
  logic                       r2_r, r2_nxt;
  logic                       upd_r, upd_nxt;

  // Output register.
  logic                        ov_r, ov_nxt;
  logic [bihr_pkg::KIND_W-1:0] okind_r, okind_nxt;
  logic [TW-1:0]               otime_r, otime_nxt;
  logic [bihr_pkg::CODE_W-1:0] ocode_r, ocode_nxt;
  logic [bihr_pkg::RATE_W-1:0] orate_r, orate_nxt;
  logic                        olast_r, olast_nxt;

  bihr_pkg::div_req_t div_req;
  bihr_pkg::div_rsp_t div_rsp;

  logic          in_acc;
  logic          slot_free;
  logic [TW-1:0] in_time;
  logic          in_beat, in_norm, in_meas;

  bihr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign slot_free = ~ov_r | out_tready;
  assign in_time   = in_tdata[31:0];
  assign in_beat   = in_tuser[0];
  assign in_norm   = in_tuser[1];
  assign in_meas   = in_tuser[2];

  always_comb begin
    state_nxt = state_r;
    prod_nxt  = prod_r;
    bt_nxt    = bt_r;
    nn_nxt    = nn_r;
    sum_nxt   = sum_r;
    prevn_nxt = prevn_r;
    t_nxt     = t_r;
    code_nxt  = code_r;
    span_nxt  = span_r;
    nn0_nxt   = nn0_r;
    div2_nxt  = div2_r;
    copy_nxt  = copy_r;
    r1_nxt    = r1_r;
    r2_nxt    = r2_r;
    upd_nxt   = upd_r;

    // The output register empties when taken; a load below refills it.
    ov_nxt    = ov_r & ~out_tready;
    okind_nxt = okind_r;
    otime_nxt = otime_r;
    ocode_nxt = ocode_r;
    orate_nxt = orate_r;
    olast_nxt = olast_r;

    div_req.start    = 1'b0;
    div_req.dividend = (NW'(prod_r) << bihr_pkg::RATE_FRAC_BITS) + NW'(span_r >> 1);
    div_req.divisor  = DW'(span_r);

    if (cfg_wr_en) begin
      prod_nxt = bihr_pkg::PROD_W'(bihr_pkg::SR_FACTOR) * bihr_pkg::PROD_W'(cfg_wr_data);
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          t_nxt    = in_time;
          code_nxt = in_tdata[39:32];
          span_nxt = in_time - bt_r[2];
          nn0_nxt  = in_time - bt_r[0];
          copy_nxt = ~in_meas;
          r1_nxt   = in_beat & (bt_r[2] != '0);
          upd_nxt  = in_beat & in_norm & prevn_r;
          r2_nxt   = in_beat & in_norm & prevn_r & (nn_r[4] != '0);
          if (in_beat) begin
            bt_nxt[2] = bt_r[1];
            bt_nxt[1] = bt_r[0];
            bt_nxt[0] = in_time;
            prevn_nxt = in_norm;
          end
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        div2_nxt  = sum_r + DW'(nn0_r);
        state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        if (upd_r) begin
          sum_nxt   = div2_r - DW'(nn_r[4]);
          nn_nxt[4] = nn_r[3];
          nn_nxt[3] = nn_r[2];
          nn_nxt[2] = nn_r[1];
          nn_nxt[1] = nn_r[0];
          nn_nxt[0] = nn0_r;
        end
        state_nxt = S_COPY;
      end
      S_COPY: begin
        if (!copy_r) begin
          state_nxt = S_DIV1;
        end else if (slot_free) begin
          ov_nxt    = 1'b1;
          okind_nxt = bihr_pkg::KIND_COPY;
          otime_nxt = t_r;
          ocode_nxt = code_r;
          orate_nxt = '0;
          olast_nxt = ~(r1_r | r2_r);
          state_nxt = S_DIV1;
        end
      end
      S_DIV1: begin
        if (r1_r) begin
          div_req.start = 1'b1;
          state_nxt     = S_DIV1W;
        end else begin
          state_nxt = S_DIV2;
        end
      end
      S_DIV1W: begin
        if (div_rsp.done) begin
          state_nxt = S_EMIT1;
        end
      end
      S_EMIT1: begin
        if (slot_free) begin
          ov_nxt    = 1'b1;
          okind_nxt = bihr_pkg::KIND_RATE3;
          otime_nxt = t_r + TW'(1);
          ocode_nxt = '0;
          orate_nxt = div_rsp.rate;
          olast_nxt = ~r2_r;
          state_nxt = S_DIV2;
        end
      end
      S_DIV2: begin
        // Twice the stored product gives the 360 factor of the six-interval rate.
        div_req.dividend = (NW'(prod_r) << (bihr_pkg::RATE_FRAC_BITS + 1)) +
                           NW'(div2_r >> 1);
        div_req.divisor  = div2_r;
        if (r2_r) begin
          div_req.start = 1'b1;
          state_nxt     = S_DIV2W;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DIV2W: begin
        if (div_rsp.done) begin
          state_nxt = S_EMIT2;
        end
      end
      S_EMIT2: begin
        if (slot_free) begin
          ov_nxt    = 1'b1;
          okind_nxt = bihr_pkg::KIND_RATE6;
          otime_nxt = t_r + TW'(2);
          ocode_nxt = '0;
          orate_nxt = div_rsp.rate;
          olast_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      prod_r  <= bihr_pkg::PROD_W'(bihr_pkg::PROD_RESET);
      bt_r    <= '{default: '0};
      nn_r    <= '{default: '0};
      sum_r   <= '0;
      prevn_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      prod_r  <= prod_nxt;
      bt_r    <= bt_nxt;
      nn_r    <= nn_nxt;
      sum_r   <= sum_nxt;
      prevn_r <= prevn_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r     <= t_nxt;
    code_r  <= code_nxt;
    span_r  <= span_nxt;
    nn0_r   <= nn0_nxt;
    div2_r  <= div2_nxt;
    copy_r  <= copy_nxt;
    r1_r    <= r1_nxt;
    r2_r    <= r2_nxt;
    upd_r   <= upd_nxt;
    okind_r <= okind_nxt;
    otime_r <= otime_nxt;
    ocode_r <= ocode_nxt;
    orate_r <= orate_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {orate_r, ocode_r, otime_r};
  assign out_tuser  = okind_r;
  assign out_tlast  = olast_r;

  // Once a word is taken the sequencer is busy with it.
  `BIHR_ASSERT_NXT(a_busy_after_accept, in_acc, !in_tready)
  // The divider is only started when it is free.
  `BIHR_ASSERT_IMP(a_div_start_free, div_req.start, !div_rsp.busy)
  // A finished division is always awaited by the sequencer.
  `BIHR_ASSERT_IMP(a_div_done_awaited, div_rsp.done, state_r == S_DIV1W || state_r == S_DIV2W)

endmodule

`default_nettype wire
